/* sv/pssm_pkg.sv */
// ----------------------------------------------------------------------------
// pssm_pkg
// Shared types, widths, codes and arithmetic helpers for the PSSM window
// scanner.
// ----------------------------------------------------------------------------
package pssm_pkg;

  localparam int MAX_WIDTH   = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int INDEX_BITS  = 20;
  localparam int SCORE_BITS  = 20;
  localparam int OFFSET_BITS = 4;
  localparam int BASE_BITS   = 2;
  localparam int NUM_BASES   = 4;
  localparam int CFG_BITS    = 5;
  localparam int CELL_BITS   = $clog2(MAX_WIDTH);

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_STREAM = 1'b1;

  localparam logic REG_MOTIF_WIDTH = 1'b0;
  localparam logic [CFG_BITS-1:0] MOTIF_WIDTH_RESET = CFG_BITS'(16);

  // Weight write toward one cell.
  typedef struct packed {
    logic                          wr_en;
    logic [BASE_BITS-1:0]          wr_base;
    logic signed [WEIGHT_BITS-1:0] wr_weight;
  } pssm_wr_t;

  // Base step broadcast to every cell.
  typedef struct packed {
    logic                 step;
    logic                 clear;
    logic [BASE_BITS-1:0] base;
  } pssm_step_t;

  // Adds a weight to a partial sum and saturates to the signed score range.
  function automatic logic signed [SCORE_BITS-1:0] sat_add(
    input logic signed [SCORE_BITS-1:0]  a,
    input logic signed [WEIGHT_BITS-1:0] b
  );
    logic signed [SCORE_BITS:0] s;
    s = {a[SCORE_BITS-1], a} + {{(SCORE_BITS+1-WEIGHT_BITS){b[WEIGHT_BITS-1]}}, b};
    if (s[SCORE_BITS] != s[SCORE_BITS-1]) begin
      sat_add = s[SCORE_BITS] ? {1'b1, {(SCORE_BITS-1){1'b0}}}
                              : {1'b0, {(SCORE_BITS-1){1'b1}}};
    end else begin
      sat_add = s[SCORE_BITS-1:0];
    end
  endfunction

endpackage

/* sv/pssm_cell.sv */
// ----------------------------------------------------------------------------
// pssm_cell
// One window offset: holds the four weights of that offset and the partial
// sum of the open window that has just passed it.
// ----------------------------------------------------------------------------
module pssm_cell
  import pssm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  pssm_wr_t                     wr,
  input  pssm_step_t                   stp,
  input  logic signed [SCORE_BITS-1:0] ps_in,
  output logic signed [SCORE_BITS-1:0] sum,
  output logic signed [SCORE_BITS-1:0] ps_out
);

  logic signed [WEIGHT_BITS-1:0] weights [NUM_BASES];
  logic signed [SCORE_BITS-1:0]  ps;

  assign sum    = sat_add(ps_in, weights[stp.base]);
  assign ps_out = ps;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BASES; i++) begin
        weights[i] <= '0;
      end
    end else if (wr.wr_en) begin
      weights[wr.wr_base] <= wr.wr_weight;
    end
  end

  // The sum moves one cell along per base; the last base of a sequence
  // empties every open window.
  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= '0;
    end else if (stp.step) begin
      ps <= stp.clear ? '0 : sum;
    end
  end

endmodule

/* sv/pssm_window_scan.sv */
// ----------------------------------------------------------------------------
// pssm_window_scan
// Scores every window of motif_width bases against a position-specific
// scoring matrix held in a row of offset cells.
// ----------------------------------------------------------------------------
// Latency: a result word is valid in the cycle after its base word is taken.
// Throughput: one input word per cycle while the output register is not
// held; every cell adds its weight to its open window in the same cycle,
// and the single output register decouples the two sides.
// Reset: weights, partial sums and the base count clear at once, and
// motif_width returns to 16; no clearing pass is needed.
module pssm_window_scan
  import pssm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input words.
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          command,
  input  logic [OFFSET_BITS-1:0]        offset,
  input  logic [BASE_BITS-1:0]          base,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  input  logic                          last,
  // Result words.
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [SCORE_BITS-1:0]  score,
  output logic [INDEX_BITS-1:0]         window_start,
  output logic                          end_of_sequence
);

  logic [CFG_BITS-1:0]          motif_width;
  logic [INDEX_BITS-1:0]        bases_seen;
  logic [INDEX_BITS-1:0]        bases_seen_next;
  logic [CELL_BITS-1:0]         w_m1;
  logic                         accept;
  logic                         stream;
  logic                         emit;
  logic [INDEX_BITS-1:0]        start;
  pssm_step_t                   stp;
  logic signed [SCORE_BITS-1:0] sums    [MAX_WIDTH];
  logic signed [SCORE_BITS-1:0] ps_regs [MAX_WIDTH];

  // Configuration register. Only the one register exists, decoded from
  // paddr[2] alone: a write with paddr[2] clear reaches it, any other is dropped.
  assign pready = 1'b1;
  assign prdata = {{(32-CFG_BITS){1'b0}}, motif_width};

  always_ff @(posedge clk) begin
    if (rst) begin
      motif_width <= MOTIF_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MOTIF_WIDTH) begin
      motif_width <= pwdata[CFG_BITS-1:0];
    end
  end

  // The effective width clamps zero to one and anything past the cell
  // count to the full row; it is kept here as width minus one.
  always_comb begin
    if (motif_width == '0) begin
      w_m1 = '0;
    end else if (motif_width > CFG_BITS'(MAX_WIDTH)) begin
      w_m1 = CELL_BITS'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CELL_BITS'(motif_width - CFG_BITS'(1));
    end
  end

  // A new word is taken whenever the output register is empty or is being
  // drained in this same cycle.
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign stream     = accept && command == CMD_STREAM;

  assign stp.step  = stream;
  assign stp.clear = last;
  assign stp.base  = base;

  // The row of cells. Cell k owns offset k; its partial sum feeds cell k+1,
  // and cell zero starts each new window from zero.
  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_cell
    pssm_wr_t wr;
    logic signed [SCORE_BITS-1:0] ps_in;

    assign wr.wr_en     = accept && command == CMD_WRITE && offset == OFFSET_BITS'(k);
    assign wr.wr_base   = base;
    assign wr.wr_weight = weight;

    if (k == 0) begin : g_head
      assign ps_in = '0;
    end else begin : g_link
      assign ps_in = ps_regs[k-1];
    end

    pssm_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .wr     (wr),
      .stp    (stp),
      .ps_in  (ps_in),
      .sum    (sums[k]),
      .ps_out (ps_regs[k])
    );
  end

  // A window closes once the sequence holds at least width bases. Its start
  // is the current index less one less than the width, except that a
  // saturated count reports the maximum index.
  assign emit = ({1'b0, bases_seen} + (INDEX_BITS+1)'(1))
                >= (INDEX_BITS+1)'({1'b0, w_m1} + (CELL_BITS+1)'(1));
  assign start = (bases_seen == INDEX_MAX) ? INDEX_MAX
                                           : bases_seen - INDEX_BITS'(w_m1);

  always_comb begin
    if (last) begin
      bases_seen_next = '0;
    end else if (bases_seen != INDEX_MAX) begin
      bases_seen_next = bases_seen + INDEX_BITS'(1);
    end else begin
      bases_seen_next = bases_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bases_seen <= '0;
    end else if (stream) begin
      bases_seen <= bases_seen_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stream && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream && emit) begin
      score           <= sums[w_m1];
      window_start    <= start;
      end_of_sequence <= last;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && command == CMD_WRITE |=> !result_valid)
    else $error("weight write produced a result word");

  a_last_resets_count: assert property (@(posedge clk) disable iff (rst)
    stream && last |=> bases_seen == '0 && ps_regs[0] == '0)
    else $error("sequence end did not clear the scan state");

  a_first_base_short: assert property (@(posedge clk) disable iff (rst)
    stream && bases_seen == '0 && w_m1 != '0 |=> !result_valid)
    else $error("result emitted before a full window");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("input taken while output register is held");
`endif

endmodule
